[design/polygon_pixel_square_clip_defines.svh]
// ----------------------------------------------------------------------------
// polygon_pixel_square_clip_defines.svh
// Assertion macros shared by the pixel clipper RTL.
// ----------------------------------------------------------------------------
`ifndef POLYGON_PIXEL_SQUARE_CLIP_DEFINES_SVH
`define POLYGON_PIXEL_SQUARE_CLIP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PPSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define PPSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ppsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsc_pkg
// Types and helpers for the polygon to pixel square clipper.
// ----------------------------------------------------------------------------
package ppsc_pkg;

    localparam int COORD_W  = 32;
    localparam int PIXEL_W  = 16;
    localparam int OCOUNT_W = 6;
    localparam int SAT_W    = 48;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [PIXEL_W-1:0] pixel_x;
        logic signed [PIXEL_W-1:0] pixel_y;
        logic                      last_vertex;
    } t_vertex_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [OCOUNT_W-1:0]       out_count;
        logic                      out_last;
        logic                      overflow;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vtx;

    // clamp to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sh7fffffff);
        lo = SAT_W'(-32'sh7fffffff - 32'sd1);
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

[design/polygon_pixel_square_clip.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_pixel_square_clip
// Clips a polygon against the unit square around a pixel centre
// (left, right, bottom, top passes) and streams the surviving vertices.
// ----------------------------------------------------------------------------
//  channel   | valid    | stall    | payload
//  ----------+----------+----------+-------------------------
//  vertex in | i_valid  | o_stall  | i_vertex (t_vertex_in)
//  result out| o_valid  | i_stall  | o_result (t_result)
//
//  Vertices load one per cycle. After the last vertex the block is busy:
//  per pass, start and first-read states; per edge, fetch, wait (not on the
//  closing edge), evaluate and next; a crossing edge adds one 32x32 multiply,
//  32 restoring divide steps, rounding and, if it enters the square, a push
//  of its end vertex. Each result is read, then held while output stalls.
//  Reset is synchronous; the vertex stores need no clearing.
`include "polygon_pixel_square_clip_defines.svh"

module polygon_pixel_square_clip
    import ppsc_pkg::*;
#(
    parameter int MAX_VERTICES    = 32,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_vertex_in i_vertex,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_result
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int BW = (COORD_FRAC_BITS + 18 > 34) ? COORD_FRAC_BITS + 18 : 34;
    localparam logic signed [BW-1:0] HALF = BW'(1) <<< (COORD_FRAC_BITS - 1);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_PSTART = 4'd1;
    localparam logic [3:0] S_PREAD0 = 4'd2;
    localparam logic [3:0] S_FETCH  = 4'd3;
    localparam logic [3:0] S_WAIT   = 4'd4;
    localparam logic [3:0] S_EVAL   = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_RND    = 4'd8;
    localparam logic [3:0] S_PUSHB  = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_PEND   = 4'd11;
    localparam logic [3:0] S_ORD    = 4'd12;
    localparam logic [3:0] S_OWAIT  = 4'd13;
    localparam logic [3:0] S_OHOLD  = 4'd14;

    t_vtx r_mem_a [MAX_VERTICES];
    t_vtx r_mem_b [MAX_VERTICES];
    t_vtx r_rd_a;
    t_vtx r_rd_b;

    logic [3:0]                r_state;
    logic [1:0]                r_pass;
    logic [CW-1:0]             r_cnt_a;
    logic [CW-1:0]             r_cnt_b;
    logic                      r_ovf;
    logic signed [PIXEL_W-1:0] r_cx;
    logic signed [PIXEL_W-1:0] r_cy;
    logic [AW-1:0]             r_i;
    logic [AW-1:0]             r_k;
    t_vtx                      r_first;
    t_vtx                      r_pa;
    t_vtx                      r_pb;
    logic [31:0]               r_den;
    logic [31:0]               r_num;
    logic [31:0]               r_m;
    logic                      r_neg;
    logic                      r_inb;
    logic signed [COORD_W-1:0] r_as;
    logic [31:0]               r_rem;
    logic [31:0]               r_quo;
    logic [4:0]                r_dcnt;
    logic                      r_out_valid;
    t_result                   r_out;

    // pass geometry
    logic signed [BW-1:0]      w_base;
    logic signed [BW-1:0]      w_bound;
    logic signed [COORD_W-1:0] w_bound_sat;
    logic signed [COORD_W-1:0] w_ap;
    logic signed [COORD_W-1:0] w_bp;
    logic signed [COORD_W-1:0] w_as;
    logic signed [COORD_W-1:0] w_bs;
    logic                      w_ina;
    logic                      w_inb;
    logic signed [BW-1:0]      w_num_full;
    logic signed [32:0]        w_num;
    logic signed [32:0]        w_den;
    logic signed [32:0]        w_m;
    logic [32:0]               w_num_abs;
    logic [32:0]               w_den_abs;
    logic [32:0]               w_m_abs;
    logic [CW-1:0]             w_n_src;
    logic                      w_last_edge;
    t_vtx                      w_src_rd;

    // divider and rounding
    logic [32:0]               w_trial;
    logic                      w_qbit;
    logic [32:0]               w_q;
    logic signed [33:0]        w_s;
    logic signed [COORD_W-1:0] w_s_sat;
    t_vtx                      w_ix;

    // store port
    logic          w_push_en;
    logic          w_push_to_a;
    t_vtx          w_push_v;
    logic [CW-1:0] w_push_cnt;
    logic          w_push_full;
    logic [AW-1:0] w_raddr;
    logic [CW+5:0] w_cnt_ext;

    assign o_stall  = (r_state != S_LOAD);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign w_base      = (r_pass[1] ? BW'(r_cy) : BW'(r_cx)) <<< COORD_FRAC_BITS;
    assign w_bound     = r_pass[0] ? w_base + HALF : w_base - HALF;
    assign w_bound_sat = sat32(SAT_W'(w_bound));

    assign w_ap = r_pass[1] ? r_pa.y : r_pa.x;
    assign w_as = r_pass[1] ? r_pa.x : r_pa.y;
    assign w_bp = r_pass[1] ? r_pb.y : r_pb.x;
    assign w_bs = r_pass[1] ? r_pb.x : r_pb.y;

    // left and bottom keep >= bound, right and top keep <= bound
    assign w_ina = r_pass[0] ? (BW'(w_ap) <= w_bound) : (BW'(w_ap) >= w_bound);
    assign w_inb = r_pass[0] ? (BW'(w_bp) <= w_bound) : (BW'(w_bp) >= w_bound);

    // on a crossing the bound lies between the ends, so num fits 33 bits
    assign w_num_full = w_bound - BW'(w_ap);
    assign w_num      = w_num_full[32:0];
    assign w_den      = 33'(w_bp) - 33'(w_ap);
    assign w_m        = 33'(w_bs) - 33'(w_as);
    assign w_num_abs  = w_num[32] ? -w_num : w_num;
    assign w_den_abs  = w_den[32] ? -w_den : w_den;
    assign w_m_abs    = w_m[32] ? -w_m : w_m;

    assign w_n_src     = r_pass[0] ? r_cnt_b : r_cnt_a;
    assign w_last_edge = ((CW'(r_i) + CW'(1)) >= w_n_src);
    assign w_src_rd    = r_pass[0] ? r_rd_b : r_rd_a;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});
    assign w_q     = {1'b0, r_quo} + 33'((r_rem >= (r_den - r_rem)) ? 1 : 0);
    assign w_s     = r_neg ? 34'(r_as) - 34'(w_q) : 34'(r_as) + 34'(w_q);
    assign w_s_sat = sat32(SAT_W'(w_s));
    assign w_ix.x  = r_pass[1] ? w_s_sat : w_bound_sat;
    assign w_ix.y  = r_pass[1] ? w_bound_sat : w_s_sat;

    assign w_cnt_ext = (CW+6)'(r_cnt_a);

    always_comb begin
        w_push_en   = 1'b0;
        w_push_to_a = r_pass[0];
        w_push_v    = r_pb;
        unique case (r_state)
            S_LOAD: begin
                w_push_en   = i_valid;
                w_push_to_a = 1'b1;
                w_push_v.x  = i_vertex.vertex_x;
                w_push_v.y  = i_vertex.vertex_y;
            end
            S_EVAL: begin
                w_push_en = w_ina && w_inb;
            end
            S_RND: begin
                w_push_en = 1'b1;
                w_push_v  = w_ix;
            end
            S_PUSHB: begin
                w_push_en = 1'b1;
            end
            default: begin
                w_push_en = 1'b0;
            end
        endcase
    end

    assign w_push_cnt  = w_push_to_a ? r_cnt_a : r_cnt_b;
    assign w_push_full = (w_push_cnt >= CW'(MAX_VERTICES));

    always_comb begin
        unique case (r_state)
            S_FETCH: w_raddr = r_i + AW'(1);
            S_ORD:   w_raddr = r_k;
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push_en && !w_push_full && w_push_to_a) begin
            r_mem_a[w_push_cnt[AW-1:0]] <= w_push_v;
        end
        if (w_push_en && !w_push_full && !w_push_to_a) begin
            r_mem_b[w_push_cnt[AW-1:0]] <= w_push_v;
        end
        r_rd_a <= r_mem_a[w_raddr];
        r_rd_b <= r_mem_b[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_pass      <= '0;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ovf       <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_valid && i_vertex.last_vertex) begin
                        r_cx    <= i_vertex.pixel_x;
                        r_cy    <= i_vertex.pixel_y;
                        r_pass  <= '0;
                        r_state <= S_PSTART;
                    end
                end
                S_PSTART: begin
                    if (r_pass[0]) begin
                        r_cnt_a <= '0;
                    end else begin
                        r_cnt_b <= '0;
                    end
                    r_state <= (w_n_src == '0) ? S_PEND : S_PREAD0;
                end
                S_PREAD0: begin
                    r_first <= w_src_rd;
                    r_pa    <= w_src_rd;
                    r_i     <= '0;
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    if (w_last_edge) begin
                        r_pb    <= r_first;
                        r_state <= S_EVAL;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_pb    <= w_src_rd;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_num <= w_num_abs[31:0];
                    r_den <= w_den_abs[31:0];
                    r_m   <= w_m_abs[31:0];
                    r_neg <= w_num[32] ^ w_m[32] ^ w_den[32];
                    r_as  <= w_as;
                    r_inb <= w_inb;
                    // skip an edge parallel to the side
                    if ((w_ina != w_inb) && (w_den != '0)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_MUL: begin
                    {r_rem, r_quo} <= r_num * r_m;
                    r_dcnt         <= '0;
                    r_state        <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_qbit ? 32'(w_trial - {1'b0, r_den}) : w_trial[31:0];
                    r_quo  <= {r_quo[30:0], w_qbit};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_state <= r_inb ? S_PUSHB : S_NEXT;
                end
                S_PUSHB: begin
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_pa <= r_pb;
                    if (w_last_edge) begin
                        r_state <= S_PEND;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_PEND: begin
                    r_pass <= r_pass + 2'd1;
                    r_k    <= '0;
                    if (r_pass != 2'd3) begin
                        r_state <= S_PSTART;
                    end else if (r_cnt_a == '0) begin
                        r_out.out_x     <= '0;
                        r_out.out_y     <= '0;
                        r_out.out_count <= '0;
                        r_out.out_last  <= 1'b1;
                        r_out.overflow  <= r_ovf;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_OHOLD;
                    end else begin
                        r_state <= S_ORD;
                    end
                end
                S_ORD: begin
                    r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    r_out.out_x     <= r_rd_a.x;
                    r_out.out_y     <= r_rd_a.y;
                    r_out.out_count <= w_cnt_ext[5:0];
                    r_out.out_last  <= ((CW'(r_k) + CW'(1)) == r_cnt_a);
                    r_out.overflow  <= r_ovf;
                    r_out_valid     <= 1'b1;
                    r_state         <= S_OHOLD;
                end
                S_OHOLD: begin
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out.out_last) begin
                            r_cnt_a <= '0;
                            r_cnt_b <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + AW'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            // store push: advance the fill count or flag the drop
            if (w_push_en) begin
                if (w_push_full) begin
                    r_ovf <= 1'b1;
                end else if (w_push_to_a) begin
                    r_cnt_a <= r_cnt_a + CW'(1);
                end else begin
                    r_cnt_b <= r_cnt_b + CW'(1);
                end
            end
        end
    end

    `PPSC_ASSERT_IMP(a_out_only_in_hold, r_out_valid, r_state == S_OHOLD, "result valid outside hold state")
    `PPSC_ASSERT_IMP(a_counts_bounded, 1'b1, (r_cnt_a <= CW'(MAX_VERTICES)) && (r_cnt_b <= CW'(MAX_VERTICES)), "vertex count above store depth")
    `PPSC_ASSERT_IMP(a_div_nonzero, r_state == S_DIV, r_den != '0, "divide by zero")
    `PPSC_ASSERT_NXT(a_clear_after_last, o_valid && !i_stall && o_result.out_last, (r_cnt_a == '0) && (r_cnt_b == '0) && !r_ovf && (r_state == S_LOAD), "state not cleared after polygon")

endmodule

[tb/polygon_pixel_square_clip_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_pixel_square_clip_tb
// Streams polygons into the pixel square clipper and checks every clipped
// vertex against a cycle-free copy of the four-pass clip computed in the
// bench. Covers corner polygons, store overflow, random polygons under three
// idle mixes, and a long output hold-off that backs up the vertex input.
// ----------------------------------------------------------------------------
module polygon_pixel_square_clip_tb;
    import ppsc_pkg::*;

    localparam int  MAX_VTX   = 32;
    localparam int  FRAC      = 16;
    localparam int  N_ITEMS   = 470;
    // vertices sent by the corner, overflow and fill tests
    localparam int  N_FIXED   = 115;
    localparam int  LIMIT     = 20000000;
    localparam int  SETTLE    = 200;
    localparam longint ONE_FX  = 64'sd1 << FRAC;
    localparam longint HALF_FX = 64'sd1 << (FRAC - 1);

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_vertex_in i_vertex;
    logic       o_valid;
    logic       i_stall;
    t_result    o_result;

    polygon_pixel_square_clip dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_vertex(i_vertex),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(o_result)
    );

    t_result pending_results[$];
    t_vtx    poly_pts[$];
    bit      poly_ovf;
    int      n_sent;
    int      n_errors;
    int      cycle_cnt;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // clip predictor
    // ------------------------------------------------------------------
    function automatic longint sat_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void add_point(ref t_vtx dst[$], input longint x, input longint y);
        t_vtx p;
        if (dst.size() >= MAX_VTX) begin
            poly_ovf = 1'b1;
            return;
        end
        p.x = COORD_W'(sat_coord(x));
        p.y = COORD_W'(sat_coord(y));
        dst.push_back(p);
    endfunction

    function automatic longint unsigned abs_val(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // one side of the square; on_y picks the axis, keep_ge keeps >= bound
    function automatic void clip_side(bit on_y, bit keep_ge, longint bound);
        t_vtx       kept[$];
        t_vtx       a, b;
        int         n, j;
        longint     ap, bp, as_, bs, num, den, m, s;
        logic [127:0] prod, quo, rem, dv;
        longint unsigned q;
        bit         ina, inb, neg;
        n = poly_pts.size();
        for (int i = 0; i < n; i++) begin
            j = (i + 1 >= n) ? 0 : i + 1;
            a = poly_pts[i];
            b = poly_pts[j];
            ap  = on_y ? longint'(a.y) : longint'(a.x);
            bp  = on_y ? longint'(b.y) : longint'(b.x);
            as_ = on_y ? longint'(a.x) : longint'(a.y);
            bs  = on_y ? longint'(b.x) : longint'(b.y);
            ina = keep_ge ? ap >= bound : ap <= bound;
            inb = keep_ge ? bp >= bound : bp <= bound;
            if (ina && inb) begin
                add_point(kept, b.x, b.y);
            end else if (ina != inb) begin
                num = bound - ap;
                den = bp - ap;
                m   = bs - as_;
                if (den != 0) begin
                    prod = 128'(abs_val(num)) * 128'(abs_val(m));
                    dv   = 128'(abs_val(den));
                    quo  = prod / dv;
                    rem  = prod - quo * dv;
                    q    = quo[63:0];
                    // round half away from zero
                    if (rem >= dv - rem) q++;
                    neg = ((num < 0) != (m < 0)) != (den < 0);
                    s   = neg ? as_ - longint'(q) : as_ + longint'(q);
                    if (on_y) add_point(kept, s, bound);
                    else      add_point(kept, bound, s);
                    if (inb) add_point(kept, b.x, b.y);
                end
            end
        end
        poly_pts = kept;
    endfunction

    function automatic void predict_vertex(t_vertex_in v);
        longint  cx, cy;
        t_result r;
        add_point(poly_pts, v.vertex_x, v.vertex_y);
        if (!v.last_vertex) return;
        cx = longint'(v.pixel_x) * ONE_FX;
        cy = longint'(v.pixel_y) * ONE_FX;
        clip_side(1'b0, 1'b1, cx - HALF_FX);
        clip_side(1'b0, 1'b0, cx + HALF_FX);
        clip_side(1'b1, 1'b1, cy - HALF_FX);
        clip_side(1'b1, 1'b0, cy + HALF_FX);
        if (poly_pts.size() == 0) begin
            r = '0;
            r.out_last = 1'b1;
            r.overflow = poly_ovf;
            pending_results.push_back(r);
        end
        for (int k = 0; k < poly_pts.size(); k++) begin
            r.out_x     = poly_pts[k].x;
            r.out_y     = poly_pts[k].y;
            r.out_count = OCOUNT_W'(poly_pts.size());
            r.out_last  = (k + 1 == poly_pts.size());
            r.overflow  = poly_ovf;
            pending_results.push_back(r);
        end
        poly_pts.delete();
        poly_ovf = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result x=%0d y=%0d cnt=%0d",
                             o_result.out_x, o_result.out_y, o_result.out_count);
            end else begin
                e = pending_results.pop_front();
                if (o_result.out_x !== e.out_x || o_result.out_y !== e.out_y ||
                    o_result.out_count !== e.out_count ||
                    o_result.out_last !== e.out_last ||
                    o_result.overflow !== e.overflow) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch exp x=%0d y=%0d cnt=%0d last=%0d ovf=%0d / got x=%0d y=%0d cnt=%0d last=%0d ovf=%0d",
                                 e.out_x, e.out_y, e.out_count, e.out_last, e.overflow,
                                 o_result.out_x, o_result.out_y, o_result.out_count,
                                 o_result.out_last, o_result.overflow);
                end
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [15:0] px, logic signed [15:0] py, bit last);
        t_vertex_in v;
        v.vertex_x    = x;
        v.vertex_y    = y;
        v.pixel_x     = px;
        v.pixel_y     = py;
        v.last_vertex = last;
        i_valid  <= 1'b1;
        i_vertex <= v;
        do @(posedge i_clk); while (o_stall);
        predict_vertex(v);
        n_sent++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // random polygon around a random centre (anywhere when wide); non-final pixel fields are noise
    task automatic send_random_polygon(int nv, bit wide);
        logic signed [15:0] px, py;
        longint cx, cy;
        logic signed [31:0] x, y;
        px = 16'($urandom);
        py = 16'($urandom);
        cx = longint'(px) * ONE_FX;
        cy = longint'(py) * ONE_FX;
        for (int i = 0; i < nv; i++) begin
            if (wide) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = 32'(cx + longint'($urandom_range(0, 4 * ONE_FX)) - 2 * ONE_FX);
                y = 32'(cy + longint'($urandom_range(0, 4 * ONE_FX)) - 2 * ONE_FX);
            end
            if (i == nv - 1) send_vertex(x, y, px, py, 1'b1);
            else             send_vertex(x, y, 16'($urandom), 16'($urandom), 1'b0);
        end
    endtask

    task automatic test_corner_polygons();
        // single vertex inside, then a single vertex outside (empty result)
        send_vertex(32'sh0000_4000, -32'sh0000_2000, 16'sd0, 16'sd0, 1'b1);
        send_vertex(32'sh0003_0000, 32'sh0000_0000, 16'sd0, 16'sd0, 1'b1);
        // square covering the whole pixel
        send_vertex(-32'sh0001_0000, -32'sh0001_0000, 16'sd0, 16'sd0, 1'b0);
        send_vertex(32'sh0001_0000, -32'sh0001_0000, 16'sd0, 16'sd0, 1'b0);
        send_vertex(32'sh0001_0000, 32'sh0001_0000, 16'sd0, 16'sd0, 1'b0);
        send_vertex(-32'sh0001_0000, 32'sh0001_0000, 16'sd0, 16'sd0, 1'b1);
        // extreme coordinates and pixel centres; sides beyond 32 bits saturate
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 16'sh7fff, 16'sh8000, 1'b0);
        send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 16'sh7fff, 16'sh8000, 1'b0);
        send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh7fff, 16'sh8000, 1'b1);
        send_vertex(32'sh8000_0000, 32'sh7fff_ffff, 16'sh8000, 16'sh7fff, 1'b0);
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 16'sh7fff, 1'b0);
        send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 16'sh8000, 16'sh7fff, 1'b1);
        // edges lying on the sides of the square
        send_vertex(-32'sh0000_8000, -32'sh0000_8000, 16'sd0, 16'sd0, 1'b0);
        send_vertex(32'sh0000_8000, -32'sh0000_8000, 16'sd0, 16'sd0, 1'b0);
        send_vertex(32'sh0000_8000, 32'sh0000_8000, 16'sd0, 16'sd0, 1'b0);
        send_vertex(-32'sh0000_8000, 32'sh0000_8000, 16'sd0, 16'sd0, 1'b1);
        // sliver with a near-tie intersection
        send_vertex(-32'sh0000_c001, 32'sh0000_0001, 16'sd0, 16'sd0, 1'b0);
        send_vertex(32'sh0000_c003, -32'sh0000_0002, 16'sd0, 16'sd0, 1'b0);
        send_vertex(32'sh0000_0001, 32'sh0000_c000, 16'sd0, 16'sd0, 1'b1);
        drain();
    endtask

    task automatic test_overflow();
        // load overflow: more vertices than the store holds
        for (int i = 0; i < MAX_VTX + 3; i++)
            send_vertex(32'(i * 1024 - 16384), 32'(((i & 1) ? 1 : -1) * 8192),
                        16'sd0, 16'sd0, i == MAX_VTX + 2);
        // pass overflow: zigzag across the left side grows the polygon
        for (int i = 0; i < MAX_VTX; i++)
            send_vertex((i & 1) ? 32'sh0000_4000 : -32'sh0001_0000,
                        32'(i * 1000 - 16000), 16'sd0, 16'sd0, i == MAX_VTX - 1);
        drain();
    endtask

    task automatic test_random_polygons(int s_pct, int r_pct, int n_items);
        int stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            case ($urandom_range(0, 19))
                0:       send_random_polygon($urandom_range(1, 8), 1'b1);
                1:       send_random_polygon($urandom_range(30, 36), 1'b0);
                default: send_random_polygon($urandom_range(1, 7), 1'b0);
            endcase
        end
        drain();
    endtask

    task automatic test_fill_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 3000;
        repeat (4) send_random_polygon(6, 1'b0);
        // pause until every clipped vertex is out, then resume
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        send_random_polygon(5, 1'b0);
        drain();
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_vertex <= '0;
        i_stall  = 1'b0;
        n_sent = 0;
        n_errors = 0;
        hold_left = 0;
        poly_ovf = 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 66;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_polygons();
        test_overflow();
        test_random_polygons(15, 66, (N_ITEMS - N_FIXED) / 3);
        test_random_polygons(66, 15, (N_ITEMS - N_FIXED) / 3);
        test_random_polygons(0, 0, (N_ITEMS - N_FIXED) / 3);
        test_fill_stall();

        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
